>>> hw/rtl/tai_pkg.sv
`default_nettype none
package tai_pkg;

	localparam int NUM_REGS   = 32;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);
	localparam int MEM_WORDS  = 256;
	localparam int MEM_ADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int PROG_LEN   = 4096;
	localparam int PC_W       = 13;
	localparam int TGT_W      = 12;
	localparam int STEP_W     = 33;
	localparam int XLEN       = 64;
	localparam int HALF       = XLEN / 2;
	localparam int CNT_W      = 7;

	localparam logic [31:0] MAX_STEPS_RST = 32'd1000000;

	// instruction kinds
	localparam logic [3:0] K_NOP    = 4'd0;
	localparam logic [3:0] K_ASSIGN = 4'd1;
	localparam logic [3:0] K_BINARY = 4'd2;
	localparam logic [3:0] K_NEGATE = 4'd3;
	localparam logic [3:0] K_LOAD   = 4'd4;
	localparam logic [3:0] K_STORE  = 4'd5;
	localparam logic [3:0] K_PRINT  = 4'd6;
	localparam logic [3:0] K_CALL   = 4'd7;
	localparam logic [3:0] K_GOTO   = 4'd8;
	localparam logic [3:0] K_BRANCH = 4'd9;

	// binary operations
	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_REM = 4'd4;
	localparam logic [3:0] OP_AND = 4'd5;
	localparam logic [3:0] OP_OR  = 4'd6;
	localparam logic [3:0] OP_XOR = 4'd7;

	// branch conditions
	localparam logic [3:0] BR_NZ = 4'd0;
	localparam logic [3:0] BR_EQ = 4'd1;
	localparam logic [3:0] BR_NE = 4'd2;
	localparam logic [3:0] BR_LT = 4'd3;
	localparam logic [3:0] BR_LE = 4'd4;
	localparam logic [3:0] BR_GT = 4'd5;
	localparam logic [3:0] BR_GE = 4'd6;

	// built-in calls
	localparam logic [3:0] CALL_MAX = 4'd0;
	localparam logic [3:0] CALL_MIN = 4'd1;
	localparam logic [3:0] CALL_ABS = 4'd2;
	localparam logic [3:0] CALL_INC = 4'd3;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_DIV_ZERO = 3'd1;
	localparam logic [2:0] ERR_MOD_ZERO = 3'd2;
	localparam logic [2:0] ERR_NO_ARGS  = 3'd3;
	localparam logic [2:0] ERR_ARG_CNT  = 3'd4;
	localparam logic [2:0] ERR_STEPS    = 3'd5;
	localparam logic [2:0] ERR_BAD_OP   = 3'd6;

	typedef struct packed {
		logic load;
		logic latch;
		logic start_long;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic long_req;
		logic long_done;
		logic out_full;
	} sts_t;

	function automatic logic slt(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
		slt = $signed(a) < $signed(b);
	endfunction

	function automatic logic [XLEN-1:0] mag(input logic [XLEN-1:0] a);
		mag = a[XLEN-1] ? (~a + XLEN'(1)) : a;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tai_muldiv.sv
`default_nettype none
module tai_muldiv (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     is_div,
	input  wire logic [tai_pkg::XLEN-1:0] a,
	input  wire logic [tai_pkg::XLEN-1:0] b,
	output logic                          done,
	output logic      [tai_pkg::XLEN-1:0] prod,
	output logic      [tai_pkg::XLEN-1:0] quo,
	output logic      [tai_pkg::XLEN-1:0] rem
);
	localparam int XL = tai_pkg::XLEN;
	localparam int HL = tai_pkg::HALF;
	localparam int CW = tai_pkg::CNT_W;

	logic          busy_q, div_q, negq_q, negr_q;
	logic [CW-1:0] cnt_q;
	logic [XL-1:0] x_q, y_q, rem_q, acc_q, pp_q;
	logic [XL:0]   shifted, trial;
	logic [HL-1:0] mx, my;
	logic          last;

	assign shifted = {rem_q, x_q[XL-1]};
	assign trial   = shifted - {1'b0, y_q};
	assign last    = div_q ? (cnt_q == CW'(XL)) : (cnt_q == CW'(4));
	assign done    = busy_q && last;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin mx = x_q[HL-1:0]; my = y_q[HL-1:0]; end
			2'd1: begin mx = x_q[HL-1:0]; my = y_q[XL-1:HL]; end
			2'd2: begin mx = x_q[XL-1:HL]; my = y_q[HL-1:0]; end
			default: begin mx = '0; my = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last;
			cnt_q  <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= is_div;
			negq_q <= a[XL-1] ^ b[XL-1];
			negr_q <= a[XL-1];
			x_q    <= is_div ? tai_pkg::mag(a) : a;
			y_q    <= is_div ? tai_pkg::mag(b) : b;
			rem_q  <= '0;
			acc_q  <= '0;
		end else if (busy_q && !last) begin
			if (div_q) begin
				// restoring step: one quotient bit
				rem_q <= trial[XL] ? shifted[XL-1:0] : trial[XL-1:0];
				x_q   <= {x_q[XL-2:0], !trial[XL]};
			end else begin
				pp_q <= mx * my;
				if (cnt_q == CW'(1))
					acc_q <= acc_q + pp_q;
				else if (cnt_q != '0)
					acc_q <= acc_q + {pp_q[HL-1:0], {HL{1'b0}}};
			end
		end
	end

	assign prod = acc_q;
	assign quo  = negq_q ? (~x_q + XL'(1)) : x_q;
	assign rem  = negr_q ? (~rem_q + XL'(1)) : rem_q;

endmodule
`default_nettype wire

>>> hw/rtl/tai_ctrl.sv
`default_nettype none
module tai_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire tai_pkg::sts_t sts,
	output tai_pkg::cmd_t      cmd
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_EXEC = 4'b0100,
		S_LONG = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE) && !sts.out_full;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.latch = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				if (sts.long_req) begin
					cmd.start_long = 1'b1;
					state_d        = S_LONG;
				end else begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_LONG: begin
				if (sts.long_done) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

>>> hw/rtl/tai_datapath.sv
`default_nettype none
module tai_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tai_pkg::cmd_t             cmd,
	output tai_pkg::sts_t                  sts,
	input  wire logic [3:0]                kind,
	input  wire logic [3:0]                op,
	input  wire logic [4:0]                dest_reg,
	input  wire logic                      a_is_imm,
	input  wire logic [tai_pkg::XLEN-1:0]  a_value,
	input  wire logic                      b_is_imm,
	input  wire logic [tai_pkg::XLEN-1:0]  b_value,
	input  wire logic [tai_pkg::TGT_W-1:0] target_pc,
	input  wire logic                      has_dest,
	input  wire logic                      arg_present,
	input  wire logic                      arg_last,
	input  wire logic                      cfg_valid,
	input  wire logic [31:0]               cfg_data,
	input  wire logic                      m_tready,
	output logic                           out_valid,
	output logic      [tai_pkg::PC_W-1:0]  next_pc,
	output logic                           print_valid,
	output logic      [tai_pkg::XLEN-1:0]  print_value,
	output logic      [2:0]                error_code,
	output logic                           halted
);
	localparam int XL = tai_pkg::XLEN;
	localparam int RW = tai_pkg::REG_IDX_W;
	localparam int AW = tai_pkg::MEM_ADDR_W;
	localparam int PW = tai_pkg::PC_W;
	localparam int SW = tai_pkg::STEP_W;

	// held item
	logic [3:0]                kind_q, op_q;
	logic [4:0]                dest_q;
	logic                      aimm_q, bimm_q, hasd_q, argp_q, argl_q;
	logic [XL-1:0]             aval_q, bval_q;
	logic [tai_pkg::TGT_W-1:0] tgt_q;

	// storage
	logic [XL-1:0]              rf [tai_pkg::NUM_REGS];
	logic [tai_pkg::NUM_REGS-1:0] rf_vld_q;
	logic [XL-1:0]              dm [tai_pkg::MEM_WORDS];
	logic [tai_pkg::MEM_WORDS-1:0] dm_vld_q;
	logic [XL-1:0]              rda_q, rdb_q, rdm_q;
	logic                       rda_v_q, rdb_v_q, rdm_v_q;

	logic [XL-1:0] a_q, b_q, mem_q;
	logic [PW-1:0] pc_q;
	logic [SW-1:0] steps_q;
	logic [31:0]   max_steps_q;
	logic          stopped_q;
	logic [2:0]    err_q;
	logic [XL-1:0] amax_q, amin_q, asum_q, afirst_q;
	logic [1:0]    acnt_q;
	logic          out_vld_q, pv_q;
	logic [XL-1:0] pval_q;
	logic [PW-1:0] npc_q;

	// muldiv
	logic          md_done;
	logic [XL-1:0] md_prod, md_quo, md_rem;

	// commit decision
	logic          skip, arg_only, step_err, exec;
	logic [XL-1:0] fmax, fmin, fsum, ffirst, r, cres;
	logic [1:0]    fcnt;
	logic [2:0]    err;
	logic          take, wr_reg, wr_mem, do_fold, do_clear;
	logic [XL-1:0] wr_val;
	logic [PW-1:0] nxt, tgt_c;

	tai_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_long),
		.is_div (op_q != tai_pkg::OP_MUL),
		.a      (a_q),
		.b      (b_q),
		.done   (md_done),
		.prod   (md_prod),
		.quo    (md_quo),
		.rem    (md_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			op_q   <= op;
			dest_q <= dest_reg;
			aimm_q <= a_is_imm;
			aval_q <= a_value;
			bimm_q <= b_is_imm;
			bval_q <= b_value;
			tgt_q  <= target_pc;
			hasd_q <= has_dest;
			argp_q <= arg_present;
			argl_q <= arg_last;
			rda_q  <= rf[a_value[RW-1:0]];
			rdb_q  <= rf[b_value[RW-1:0]];
			rdm_q  <= dm[a_value[AW-1:0]];
			rda_v_q <= rf_vld_q[a_value[RW-1:0]];
			rdb_v_q <= rf_vld_q[b_value[RW-1:0]];
			rdm_v_q <= dm_vld_q[a_value[AW-1:0]];
		end
		if (cmd.latch) begin
			// an out-of-range index or a never-written entry reads zero
			a_q   <= aimm_q ? aval_q
				: ((aval_q < XL'(tai_pkg::NUM_REGS)) && rda_v_q) ? rda_q : '0;
			b_q   <= bimm_q ? bval_q
				: ((bval_q < XL'(tai_pkg::NUM_REGS)) && rdb_v_q) ? rdb_q : '0;
			mem_q <= ((aval_q < XL'(tai_pkg::MEM_WORDS)) && rdm_v_q) ? rdm_q : '0;
		end
		if (wr_reg) rf[dest_q[RW-1:0]] <= wr_val;
		if (wr_mem) dm[aval_q[AW-1:0]] <= b_q;
	end

	always_comb begin
		skip     = stopped_q || (pc_q >= PW'(tai_pkg::PROG_LEN));
		arg_only = (kind_q == tai_pkg::K_CALL) && !argl_q;
		step_err = steps_q > {1'b0, max_steps_q};
		exec     = !skip && !arg_only && !step_err;
		tgt_c    = ({1'b0, tgt_q} > PW'(tai_pkg::PROG_LEN)) ? PW'(tai_pkg::PROG_LEN)
			: {1'b0, tgt_q};

		// fold the current argument into the running call state
		fmax = amax_q; fmin = amin_q; fsum = asum_q; ffirst = afirst_q; fcnt = acnt_q;
		if (argp_q) begin
			if (acnt_q == 2'd0) begin
				fmax = a_q; fmin = a_q; ffirst = a_q;
			end else begin
				if (tai_pkg::slt(amax_q, a_q)) fmax = a_q;
				if (tai_pkg::slt(a_q, amin_q)) fmin = a_q;
			end
			fsum = asum_q + a_q;
			if (acnt_q != 2'd2) fcnt = acnt_q + 2'd1;
		end

		err  = tai_pkg::ERR_NONE;
		r    = '0;
		cres = fsum;
		take = 1'b0;
		case (op_q)
			tai_pkg::OP_ADD: r = a_q + b_q;
			tai_pkg::OP_SUB: r = a_q - b_q;
			tai_pkg::OP_MUL: r = md_prod;
			tai_pkg::OP_DIV: begin
				if (b_q == '0) err = tai_pkg::ERR_DIV_ZERO;
				r = md_quo;
			end
			tai_pkg::OP_REM: begin
				if (b_q == '0) err = tai_pkg::ERR_MOD_ZERO;
				r = md_rem;
			end
			tai_pkg::OP_AND: r = a_q & b_q;
			tai_pkg::OP_OR:  r = a_q | b_q;
			tai_pkg::OP_XOR: r = a_q ^ b_q;
			default:         err = tai_pkg::ERR_BAD_OP;
		endcase
		if (kind_q != tai_pkg::K_BINARY) err = tai_pkg::ERR_NONE;

		case (kind_q)
			tai_pkg::K_CALL: begin
				case (op_q)
					tai_pkg::CALL_MAX: begin
						cres = fmax;
						if (fcnt == 2'd0) err = tai_pkg::ERR_NO_ARGS;
					end
					tai_pkg::CALL_MIN: begin
						cres = fmin;
						if (fcnt == 2'd0) err = tai_pkg::ERR_NO_ARGS;
					end
					tai_pkg::CALL_ABS: begin
						cres = tai_pkg::mag(ffirst);
						if (fcnt != 2'd1) err = tai_pkg::ERR_ARG_CNT;
					end
					tai_pkg::CALL_INC: begin
						cres = ffirst + XL'(1);
						if (fcnt != 2'd1) err = tai_pkg::ERR_ARG_CNT;
					end
					default: cres = fsum;
				endcase
			end
			tai_pkg::K_BRANCH: begin
				case (op_q)
					tai_pkg::BR_NZ: take = a_q != '0;
					tai_pkg::BR_EQ: take = a_q == b_q;
					tai_pkg::BR_NE: take = a_q != b_q;
					tai_pkg::BR_LT: take = tai_pkg::slt(a_q, b_q);
					tai_pkg::BR_LE: take = !tai_pkg::slt(b_q, a_q);
					tai_pkg::BR_GT: take = tai_pkg::slt(b_q, a_q);
					tai_pkg::BR_GE: take = !tai_pkg::slt(a_q, b_q);
					default:        err  = tai_pkg::ERR_BAD_OP;
				endcase
			end
			default: begin
				if (kind_q > tai_pkg::K_BRANCH) err = tai_pkg::ERR_BAD_OP;
			end
		endcase

		if (!exec) err = (!skip && !arg_only) ? tai_pkg::ERR_STEPS : tai_pkg::ERR_NONE;

		wr_val = a_q;
		case (kind_q)
			tai_pkg::K_BINARY: wr_val = r;
			tai_pkg::K_NEGATE: wr_val = '0 - a_q;
			tai_pkg::K_LOAD:   wr_val = mem_q;
			tai_pkg::K_CALL:   wr_val = cres;
			default:           wr_val = a_q;
		endcase

		wr_reg = cmd.commit && exec && (err == tai_pkg::ERR_NONE)
			&& ({1'b0, dest_q} < 6'(tai_pkg::NUM_REGS))
			&& ((kind_q == tai_pkg::K_ASSIGN) || (kind_q == tai_pkg::K_BINARY)
				|| (kind_q == tai_pkg::K_NEGATE) || (kind_q == tai_pkg::K_LOAD)
				|| ((kind_q == tai_pkg::K_CALL) && hasd_q));
		wr_mem = cmd.commit && exec && (kind_q == tai_pkg::K_STORE)
			&& (aval_q < XL'(tai_pkg::MEM_WORDS));
		do_fold  = !skip && arg_only && argp_q;
		do_clear = exec && (kind_q == tai_pkg::K_CALL);

		nxt = pc_q + PW'(1);
		if (skip || arg_only || err != tai_pkg::ERR_NONE) nxt = pc_q;
		else if ((kind_q == tai_pkg::K_GOTO) || ((kind_q == tai_pkg::K_BRANCH) && take))
			nxt = tgt_c;
	end

	assign sts.long_req  = exec && (kind_q == tai_pkg::K_BINARY)
		&& ((op_q == tai_pkg::OP_MUL)
			|| (((op_q == tai_pkg::OP_DIV) || (op_q == tai_pkg::OP_REM)) && (b_q != '0)));
	assign sts.long_done = md_done;
	assign sts.out_full  = out_vld_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q    <= '0;
			dm_vld_q    <= '0;
			pc_q        <= '0;
			steps_q     <= '0;
			max_steps_q <= tai_pkg::MAX_STEPS_RST;
			stopped_q   <= 1'b0;
			err_q       <= tai_pkg::ERR_NONE;
			amax_q      <= '0;
			amin_q      <= '0;
			asum_q      <= '0;
			afirst_q    <= '0;
			acnt_q      <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_valid) max_steps_q <= cfg_data;
			if (wr_reg) rf_vld_q[dest_q[RW-1:0]] <= 1'b1;
			if (wr_mem) dm_vld_q[aval_q[AW-1:0]] <= 1'b1;
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
				pc_q      <= nxt;
				if (exec) steps_q <= steps_q + SW'(1);
				if (err != tai_pkg::ERR_NONE) begin
					stopped_q <= 1'b1;
					err_q     <= err;
				end
				if (do_clear) begin
					amax_q <= '0; amin_q <= '0; asum_q <= '0; afirst_q <= '0;
					acnt_q <= '0;
				end else if (do_fold) begin
					amax_q <= fmax; amin_q <= fmin; asum_q <= fsum; afirst_q <= ffirst;
					acnt_q <= fcnt;
				end
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			npc_q  <= nxt;
			pv_q   <= exec && (kind_q == tai_pkg::K_PRINT) && (err == tai_pkg::ERR_NONE);
			pval_q <= (exec && (kind_q == tai_pkg::K_PRINT)) ? a_q : '0;
		end
	end

	assign out_valid   = out_vld_q;
	assign next_pc     = npc_q;
	assign print_valid = pv_q;
	assign print_value = pv_q ? pval_q : '0;
	assign error_code  = err_q;
	assign halted      = stopped_q;

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q) else $error("halt flag dropped");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && stopped_q) |=> (pc_q == $past(pc_q)))
		else $error("pc moved while halted");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.out_full) else $error("result overwritten");

endmodule
`default_nettype wire

>>> hw/rtl/three_address_instruction_executor_core.sv
`default_nettype none
// Three-address instruction executor. Each s_ transaction carries one instruction at the
// current pc (nop, assign, binary op, negate, load, store, print, goto, compare-branch, or
// one argument of a built-in call) and yields exactly one m_ transaction with the next pc,
// an optional printed value and the sticky error state. One instruction is in flight at a
// time. An item passes through acceptance with the register-file and data-memory read,
// operand select, then execute and commit, which registers the result. A multiply adds a
// long phase that forms three 32x32 partial products through one multiplier, and a divide
// or modulo adds one that yields one quotient bit per cycle. The next item is accepted
// only while the result register is empty or in the cycle its result transaction is taken,
// so a stalled m_ side holds the s_ side. Registers and data memory read zero until
// written. Arithmetic wraps at 64 bits; after the first error the block holds its pc and
// repeats the error. max_steps is written through the cfg_ port, which is always ready;
// write it only while the block is idle.
module three_address_instruction_executor_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// op[3:0], dest_reg[8:4], a_value[72:9], b_value[136:73], target_pc[148:137],
	// has_dest[149], arg_present[150], zero fill
	input  wire logic [151:0] s_tdata,
	// kind[3:0], a_is_imm[4], b_is_imm[5]
	input  wire logic [5:0]   s_tuser,
	input  wire logic         s_tlast,   // arg_last
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// next_pc[12:0], print_value[76:13], error_code[79:77], halted[80], zero fill
	output logic      [87:0]  m_tdata,
	output logic              m_tuser,   // print_valid
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data
);
	tai_pkg::cmd_t cmd;
	tai_pkg::sts_t sts;

	logic [tai_pkg::PC_W-1:0] next_pc;
	logic [tai_pkg::XLEN-1:0] print_value;
	logic [2:0]               error_code;
	logic                     halted;

	// always take configuration
	assign cfg_ready = 1'b1;

	tai_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tai_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (s_tuser[3:0]),
		.op          (s_tdata[3:0]),
		.dest_reg    (s_tdata[8:4]),
		.a_is_imm    (s_tuser[4]),
		.a_value     (s_tdata[72:9]),
		.b_is_imm    (s_tuser[5]),
		.b_value     (s_tdata[136:73]),
		.target_pc   (s_tdata[148:137]),
		.has_dest    (s_tdata[149]),
		.arg_present (s_tdata[150]),
		.arg_last    (s_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.m_tready    (m_tready),
		.out_valid   (m_tvalid),
		.next_pc     (next_pc),
		.print_valid (m_tuser),
		.print_value (print_value),
		.error_code  (error_code),
		.halted      (halted)
	);

	// pack the result fields, lowest first
	assign m_tdata = {7'd0, halted, error_code, print_value, next_pc};

endmodule
`default_nettype wire
